// ===== rtl/sliding_median_abs_deviation_macros.svh =====
// Assertion macros shared by the sliding median deviation RTL.
// Each macro expects signals named clock and reset in the including scope.
`ifndef SLIDING_MEDIAN_ABS_DEVIATION_MACROS_SVH
`define SLIDING_MEDIAN_ABS_DEVIATION_MACROS_SVH

`ifndef ASSERT_OFF

// Holds at every clock edge outside reset.
`define SMAD_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("%m: check failed");

// Implication checked at every clock edge outside reset.
`define SMAD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: implication failed");

`else

`define SMAD_ASSERT(lbl, prop)
`define SMAD_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

// ===== rtl/smad_pkg.sv =====
// Shared constants, types and command codes for the sliding median deviation block.
// Used by smad_cell, smad_chain and the top level.
package smad_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int SAMPLE_W   = 32;
   localparam int SIZE_W     = 7;
   localparam int COST_W     = 38;
   localparam int AGE_W      = $clog2(WINDOW_MAX);
   localparam int CNT_W      = AGE_W + 1;

   localparam logic [AGE_W-1:0]  AGE_OLDEST = AGE_W'(WINDOW_MAX - 1);
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(3);

   typedef struct packed {
      logic                vld;
      logic [AGE_W-1:0]    age;
      logic [SAMPLE_W-1:0] val;
   } cell_type;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_CLEAR,
      CMD_EVICT,
      CMD_INSERT,
      CMD_ROTATE
   } chain_cmd_type;

endpackage

// ===== rtl/smad_cell.sv =====
// One cell of the sorted sample row: holds a sample, its age and a valid bit.
// Depends on smad_pkg for the cell type and the row commands.
module smad_cell
   import smad_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  chain_cmd_type       cmd,
   input  logic [SAMPLE_W-1:0] smp,
   input  cell_type            below,
   input  logic                below_gt,
   input  cell_type            above,
   input  logic                evict_hit,
   output cell_type            q,
   output logic                gt,
   output logic                oldest
);

   logic                vld_ff;
   logic [AGE_W-1:0]    age_ff;
   logic [SAMPLE_W-1:0] val_ff;
   cell_type            cell_in;

   assign q      = '{vld: vld_ff, age: age_ff, val: val_ff};
   // An empty cell ranks above every sample, so empty cells stay at the top.
   assign gt     = !vld_ff || (smp < val_ff);
   assign oldest = vld_ff && (age_ff == AGE_OLDEST);

   always_comb begin
      cell_in = q;
      case (cmd)
         CMD_HOLD: begin
            cell_in = q;
         end
         CMD_CLEAR: begin
            cell_in.vld = 1'b0;
         end
         CMD_EVICT: begin
            if (evict_hit) begin
               cell_in = above;
            end
         end
         CMD_INSERT: begin
            // The new sample lands in the lowest cell that holds a larger value;
            // every cell above it takes its lower neighbor.
            if (gt && !below_gt) begin
               cell_in = '{vld: 1'b1, age: '0, val: smp};
            end else if (gt) begin
               cell_in     = below;
               cell_in.age = below.age + 1'b1;
            end else begin
               cell_in.age = age_ff + 1'b1;
            end
         end
         CMD_ROTATE: begin
            cell_in = above;
         end
         default: begin
            cell_in = q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= cell_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      age_ff <= cell_in.age;
      val_ff <= cell_in.val;
   end

endmodule

// ===== rtl/smad_chain.sv =====
// Row of WINDOW_MAX cells kept in ascending sample order, lowest value in cell 0.
// Depends on smad_pkg and smad_cell.
module smad_chain
   import smad_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  chain_cmd_type       cmd,
   input  logic [SAMPLE_W-1:0] smp,
   output cell_type            head
);

   localparam logic [WINDOW_MAX-1:0] ALL_ONES = {WINDOW_MAX{1'b1}};

   cell_type                cell_q [WINDOW_MAX];
   cell_type                cell_above [WINDOW_MAX];
   cell_type                cell_below [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]   gt_vec;
   logic [WINDOW_MAX-1:0]   gt_below;
   logic [WINDOW_MAX-1:0]   oldest_vec;
   logic [WINDOW_MAX-1:0]   evict_hit;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      // A cell at or above the evicted one takes its upper neighbor.
      assign evict_hit[i] = |(oldest_vec & (ALL_ONES >> (WINDOW_MAX - 1 - i)));

      if (i == 0) begin : g_bottom
         assign cell_below[i] = '0;
         assign gt_below[i]   = 1'b0;
      end else begin : g_inner
         assign cell_below[i] = cell_q[i-1];
         assign gt_below[i]   = gt_vec[i-1];
      end

      if (i == WINDOW_MAX - 1) begin : g_top
         // The top cell closes the ring while rotating and empties on eviction.
         assign cell_above[i] = (cmd == CMD_ROTATE) ? cell_q[0] : cell_type'('0);
      end else begin : g_lower
         assign cell_above[i] = cell_q[i+1];
      end

      smad_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .smp       (smp),
         .below     (cell_below[i]),
         .below_gt  (gt_below[i]),
         .above     (cell_above[i]),
         .evict_hit (evict_hit[i]),
         .q         (cell_q[i]),
         .gt        (gt_vec[i]),
         .oldest    (oldest_vec[i])
      );
   end

   assign head = cell_q[0];

endmodule

// ===== rtl/sliding_median_abs_deviation.sv =====
// Sliding-window median absolute deviation sum: top level with control and accumulator.
// Depends on smad_pkg, smad_chain (and smad_cell below it) and the assertion macro header.
//
// The block keeps the last 64 samples in a row of cells sorted by value, each tagged with
// its age. In the cycle that accepts a beat on req_ the row evicts its oldest sample when
// full (a restart clears it instead); then ST_INSERT inserts the new one in sorted
// position. An item that leaves fewer than window_size samples since the last restart
// gives no result and the block returns from ST_INSERT to idle. Otherwise the row rotates
// once through a single 38-bit accumulator, one cell per cycle in 64 steps, and the result
// is registered in ST_FINISH; a new beat is accepted only while idle. A result waiting
// on rsp_ holds the block in ST_FINISH until taken. window_size of zero acts as 1 and
// values above 64 act as 64; write it only while the block is idle.
`include "sliding_median_abs_deviation_macros.svh"

module sliding_median_abs_deviation
   import smad_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [31:0]        req_tdata,   // [31:0] sample
   input  logic               req_tuser,   // [0] restart
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [39:0]        rsp_tdata,   // [37:0] cost, [39:38] zero
   input  logic               csr_we,
   input  logic [SIZE_W-1:0]  csr_wdata    // [6:0] window_size
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type           state_ff;
   logic [CNT_W-1:0]    fill_ff;
   logic [CNT_W-1:0]    fill_in;
   logic [SIZE_W-1:0]   size_ff;
   logic [SAMPLE_W-1:0] smp_ff;
   logic [AGE_W-1:0]    scan_ff;
   logic [CNT_W-1:0]    rank_ff;
   logic [COST_W-1:0]   acc_ff;
   logic [COST_W-1:0]   acc_in;
   logic                rsp_tvalid_ff;
   logic [COST_W-1:0]   rsp_cost_ff;

   logic                req_accept;
   chain_cmd_type       cmd;
   cell_type            head;
   logic [CNT_W-1:0]    k_eff;
   logic [CNT_W-1:0]    med_rank;
   logic                member;
   logic [COST_W-1:0]   operand;
   logic                out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(40 - COST_W){1'b0}}, rsp_cost_ff};
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      if (size_ff == '0) begin
         k_eff = CNT_W'(1);
      end else if (size_ff > SIZE_W'(WINDOW_MAX)) begin
         k_eff = CNT_W'(WINDOW_MAX);
      end else begin
         k_eff = CNT_W'(size_ff);
      end
   end

   assign med_rank = (k_eff - 1'b1) >> 1;
   assign fill_in  = (fill_ff == CNT_W'(WINDOW_MAX)) ? fill_ff : fill_ff + 1'b1;

   always_comb begin
      cmd = CMD_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_tuser) begin
               cmd = CMD_CLEAR;
            end else if (req_accept && (fill_ff == CNT_W'(WINDOW_MAX))) begin
               cmd = CMD_EVICT;
            end
         end
         ST_INSERT: cmd = CMD_INSERT;
         ST_SCAN:   cmd = CMD_ROTATE;
         default:   cmd = CMD_HOLD;
      endcase
   end

   smad_chain u_chain (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .smp   (smp_ff),
      .head  (head)
   );

   // Below the median a sample counts negative, above it positive; for an even window
   // the median itself counts negative once, which balances the sum.
   assign member  = head.vld && ({1'b0, head.age} < k_eff);
   assign operand = ((rank_ff == med_rank) && k_eff[0]) ? '0 : COST_W'(head.val);
   assign acc_in  = (rank_ff <= med_rank) ? acc_ff - operand : acc_ff + operand;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_we) begin
         size_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (req_tuser) begin
                     fill_ff <= '0;
                  end
                  state_ff <= ST_INSERT;
               end
            end
            ST_INSERT: begin
               fill_ff  <= fill_in;
               state_ff <= (fill_in >= k_eff) ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
               if (scan_ff == AGE_OLDEST) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_cost_ff <= acc_ff;
                  state_ff    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // A new result may replace the one being taken in the same cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if ((state_ff == ST_FINISH) && out_free) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         smp_ff <= req_tdata[SAMPLE_W-1:0];
      end
      if (state_ff == ST_INSERT) begin
         scan_ff <= '0;
         rank_ff <= '0;
         acc_ff  <= '0;
      end else if (state_ff == ST_SCAN) begin
         scan_ff <= scan_ff + 1'b1;
         if (member) begin
            rank_ff <= rank_ff + 1'b1;
            acc_ff  <= acc_in;
         end
      end
   end

   `SMAD_ASSERT_IMP(a_scan_needs_full_window, state_ff == ST_SCAN, fill_ff >= k_eff)
   `SMAD_ASSERT_IMP(a_all_members_counted, state_ff == ST_FINISH, rank_ff == k_eff)
   `SMAD_ASSERT_IMP(a_result_from_finish, $rose(rsp_tvalid_ff), $past(state_ff == ST_FINISH))
   `SMAD_ASSERT(a_fill_bounded, fill_ff <= CNT_W'(WINDOW_MAX))

endmodule
